>>> hw/rtl/chpi_pkg.sv
package chpi_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int VALUE_BITS  = (VALUE_WIDTH < 16) ? 16 : ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);

	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 35;
	localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
	localparam int ACC_W   = 38;

	typedef enum logic [1:0] {
		MODE_BEGIN  = 2'd0,
		MODE_END    = 2'd1,
		MODE_UPDATE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_angle;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_angle;
		logic        [15:0] step_time;
		logic        [16:0] fraction;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_angle;
		logic signed [31:0] out_dx;
		logic signed [31:0] out_dy;
		logic signed [31:0] out_dangle;
	} out_beat_t;

	typedef struct packed {
		logic        [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mac_op_t;

	// clamp to the signed VALUE_BITS range
	function automatic logic signed [31:0] sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = (ACC_W'(1) <<< (VALUE_BITS - 1)) - ACC_W'(1);
		lo = -hi - ACC_W'(1);
		if (v > hi) begin
			sat = hi[31:0];
		end else if (v < lo) begin
			sat = lo[31:0];
		end else begin
			sat = v[31:0];
		end
	endfunction

	function automatic logic signed [ACC_W-1:0] sx(input logic signed [31:0] v);
		sx = {{(ACC_W-32){v[31]}}, v};
	endfunction

endpackage

>>> hw/rtl/chpi_mac.sv
module chpi_mac (
	input  logic                                clk,
	input  logic                                mul_en,
	input  chpi_pkg::mac_op_t                   op,
	input  logic signed [chpi_pkg::ACC_W-1:0]   addend,
	output logic signed [31:0]                  result
);

	logic signed [chpi_pkg::PROD_W-1:0]  prod_s1;
	logic signed [chpi_pkg::PROD_W:0]    biased;
	logic signed [chpi_pkg::ACC_W-1:0]   rounded;
	logic signed [chpi_pkg::ACC_W-1:0]   sum;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= $signed({1'b0, op.a}) * op.b;
		end
	end

	// round half up, then add and clamp
	assign biased  = {prod_s1[chpi_pkg::PROD_W-1], prod_s1} + (chpi_pkg::PROD_W+1)'(32768);
	assign rounded = biased[16 +: chpi_pkg::ACC_W];
	assign sum     = rounded + addend;
	assign result  = chpi_pkg::sat(sum);

endmodule

>>> hw/rtl/cubic_hermite_pose_interpolator.sv
// channel | direction | handshake          | payload
// cfg     | in        | cfg_we             | cfg_wdata (body_is_static)
// in      | in        | in_valid, in_stall | in_beat  (chpi_pkg::in_beat_t)
// out     | out       | out_valid, out_stall | out_beat (chpi_pkg::out_beat_t)
// Begin and no-op beats finish in the accept cycle, as does end on a static body.
// Otherwise end and update run in steps, and update then loads the output register.
// Each step is a multiply and an accumulate state through the one shared 17x35 multiply /
// round / clamp unit. A static-body update goes to the done state to load the held pose.
// in_stall is high while a beat is in work; a stalled result holds in the output register.
// arst_n clears held pose, rate, coefficients, the body_is_static register and control state.
module cubic_hermite_pose_interpolator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  chpi_pkg::in_beat_t    in_beat,
	output logic                  out_valid,
	input  logic                  out_stall,
	output chpi_pkg::out_beat_t   out_beat
);

	chpi_pkg::state_t state_q, state_nxt;
	chpi_pkg::mode_t  mode_q;
	logic [2:0]  op_q;
	logic [1:0]  c_q;
	logic        static_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] hp_q  [3];
	logic signed [31:0] hr_q  [3];
	logic signed [31:0] k0_q  [3];
	logic signed [31:0] k1_q  [3];
	logic signed [31:0] k2_q  [3];
	logic signed [31:0] k3_q  [3];
	logic signed [31:0] a_q, b_q, e_q;
	logic [15:0] dt_q;
	logic [16:0] ds_q;

	logic                 out_valid_q;
	chpi_pkg::out_beat_t  out_q;

	logic accept, mul_en, acc_wr, out_load, last_op;
	logic signed [chpi_pkg::ACC_W-1:0] p0, v0, dx, s, b_sel, addend;
	chpi_pkg::mac_op_t  mop;
	logic signed [31:0] mac_res;

	assign accept  = in_valid && !in_stall;
	assign last_op = (mode_q == chpi_pkg::MODE_END) ? (op_q == 3'd2) : (op_q == 3'd4);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			chpi_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_beat.mode == chpi_pkg::MODE_UPDATE) begin
						state_nxt = static_q ? chpi_pkg::ST_DONE : chpi_pkg::ST_MUL;
					end else if (in_beat.mode == chpi_pkg::MODE_END && !static_q) begin
						state_nxt = chpi_pkg::ST_MUL;
					end
				end
			end
			chpi_pkg::ST_MUL: state_nxt = chpi_pkg::ST_ACC;
			chpi_pkg::ST_ACC: begin
				if (last_op && c_q == 2'd2) begin
					state_nxt = (mode_q == chpi_pkg::MODE_END) ? chpi_pkg::ST_IDLE
						: chpi_pkg::ST_DONE;
				end else begin
					state_nxt = chpi_pkg::ST_MUL;
				end
			end
			chpi_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = chpi_pkg::ST_IDLE;
				end
			end
			default: state_nxt = chpi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		mul_en   = 1'b0;
		acc_wr   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			chpi_pkg::ST_IDLE: in_stall = 1'b0;
			chpi_pkg::ST_MUL:  mul_en = 1'b1;
			chpi_pkg::ST_ACC:  acc_wr = 1'b1;
			chpi_pkg::ST_DONE: out_load = !out_valid_q || !out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	// operand and addend selection for the current step
	always_comb begin
		p0     = chpi_pkg::sx(hp_q[c_q]);
		v0     = chpi_pkg::sx(hr_q[c_q]);
		dx     = chpi_pkg::sx(pos_q[c_q]) - p0;
		s      = chpi_pkg::sx(vel_q[c_q]) + v0;
		b_sel  = '0;
		addend = '0;
		if (mode_q == chpi_pkg::MODE_END) begin
			case (op_q)
				3'd0: begin
					b_sel  = s;
					addend = -(dx <<< 1);
				end
				3'd1: begin
					b_sel  = -(s + v0);
					addend = dx + (dx <<< 1);
				end
				default: begin
					b_sel  = v0;
					addend = '0;
				end
			endcase
		end else begin
			case (op_q)
				3'd0: begin
					b_sel  = chpi_pkg::sx(k3_q[c_q]);
					addend = chpi_pkg::sx(k2_q[c_q]);
				end
				3'd1: begin
					b_sel  = chpi_pkg::sx(a_q);
					addend = chpi_pkg::sx(k1_q[c_q]);
				end
				3'd2: begin
					b_sel  = chpi_pkg::sx(k3_q[c_q]) + (chpi_pkg::sx(k3_q[c_q]) <<< 1);
					addend = chpi_pkg::sx(k2_q[c_q]) <<< 1;
				end
				3'd3: begin
					b_sel  = chpi_pkg::sx(b_q);
					addend = chpi_pkg::sx(k0_q[c_q]);
				end
				default: begin
					b_sel  = chpi_pkg::sx(e_q);
					addend = chpi_pkg::sx(k1_q[c_q]);
				end
			endcase
		end
		mop.a = (mode_q == chpi_pkg::MODE_END) ? {1'b0, dt_q} : ds_q;
		mop.b = b_sel[chpi_pkg::MUL_B_W-1:0];
	end

	chpi_mac u_mac (
		.clk    (clk),
		.mul_en (mul_en),
		.op     (mop),
		.addend (addend),
		.result (mac_res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_beat.mode;
			pos_q[0] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.pos_x));
			pos_q[1] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.pos_y));
			pos_q[2] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.pos_angle));
			vel_q[0] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.vel_x));
			vel_q[1] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.vel_y));
			vel_q[2] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.vel_angle));
			dt_q     <= in_beat.step_time;
			ds_q     <= in_beat.fraction;
		end
		if (acc_wr && mode_q == chpi_pkg::MODE_UPDATE) begin
			case (op_q)
				3'd0:    a_q <= mac_res;
				3'd1:    b_q <= mac_res;
				3'd2:    e_q <= mac_res;
				default: ;
			endcase
		end
		if (out_load) begin
			out_q.out_x      <= hp_q[0];
			out_q.out_y      <= hp_q[1];
			out_q.out_angle  <= hp_q[2];
			out_q.out_dx     <= hr_q[0];
			out_q.out_dy     <= hr_q[1];
			out_q.out_dangle <= hr_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chpi_pkg::ST_IDLE;
			op_q        <= '0;
			c_q         <= '0;
			static_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				hp_q[i] <= '0;
				hr_q[i] <= '0;
				k0_q[i] <= '0;
				k1_q[i] <= '0;
				k2_q[i] <= '0;
				k3_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				static_q <= cfg_wdata;
			end
			if (accept) begin
				op_q <= '0;
				c_q  <= '0;
				if (in_beat.mode == chpi_pkg::MODE_BEGIN && !static_q) begin
					hp_q[0] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.pos_x));
					hp_q[1] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.pos_y));
					hp_q[2] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.pos_angle));
					hr_q[0] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.vel_x));
					hr_q[1] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.vel_y));
					hr_q[2] <= chpi_pkg::sat(chpi_pkg::sx(in_beat.vel_angle));
				end
			end
			if (acc_wr) begin
				if (last_op) begin
					op_q <= '0;
					c_q  <= c_q + 2'd1;
				end else begin
					op_q <= op_q + 3'd1;
				end
				if (mode_q == chpi_pkg::MODE_END) begin
					case (op_q)
						3'd0: k3_q[c_q] <= mac_res;
						3'd1: k2_q[c_q] <= mac_res;
						default: begin
							k1_q[c_q] <= mac_res;
							k0_q[c_q] <= hp_q[c_q];
						end
					endcase
				end else begin
					case (op_q)
						3'd3:    hp_q[c_q] <= mac_res;
						3'd4:    hr_q[c_q] <= mac_res;
						default: ;
					endcase
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == chpi_pkg::ST_DONE))
		else $error("result beat raised without a finished update");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == chpi_pkg::ST_ACC |-> $past(state_q == chpi_pkg::ST_MUL))
		else $error("accumulate step without a preceding multiply");

	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chpi_pkg::ST_MUL || state_q == chpi_pkg::ST_ACC)
		|-> (c_q != 2'd3 && (mode_q == chpi_pkg::MODE_END ? op_q < 3'd3 : op_q < 3'd5)))
		else $error("sequencer step out of range");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_beat.mode == chpi_pkg::MODE_UPDATE) |=> in_stall)
		else $error("update beat did not hold off the input");

endmodule

>>> test/cubic_hermite_pose_interpolator_test.sv
module cubic_hermite_pose_interpolator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int CHUNK_BEATS    = 560;
	localparam int STATIC_BEATS   = 150;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	chpi_pkg::in_beat_t  in_beat;
	logic                out_valid;
	logic                out_stall;
	chpi_pkg::out_beat_t out_beat;

	cubic_hermite_pose_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	// predicted body state
	longint pose_hold[3];
	longint rate_hold[3];
	longint hermite_coef[4][3];
	bit     body_static;

	chpi_pkg::out_beat_t expected_poses[$];

	int mismatches      = 0;
	int results_checked = 0;
	int beats_sent      = 0;
	int updates_sent    = 0;
	int static_writes   = 0;
	int idle_cycles     = 0;
	int stall_left      = 0;
	bit source_throttle = 1'b0;
	bit sink_throttle   = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clamp_value(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (chpi_pkg::VALUE_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// Q16.16 product back to Q16.16, halves round up
	function automatic longint q16_round(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [31:0] rand_q16();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 32'($urandom_range(0, 32'h1f_ffff)) - 32'h10_0000;
		if (r < 70) return 32'($urandom_range(0, 32'h7ff_ffff)) - 32'h400_0000;
		if (r < 90) return $urandom();
		case ($urandom_range(0, 4))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return 32'h0001_0000;
		endcase
	endfunction

	function automatic logic [15:0] rand_step();
		if ($urandom_range(0, 9) != 0) return 16'($urandom_range(0, 65535));
		return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
	endfunction

	function automatic logic [16:0] rand_fraction();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return 17'($urandom_range(0, 65536));
		if (r < 90) return $urandom_range(0, 1) ? 17'd65536 : 17'd0;
		return 17'($urandom_range(65537, 131071));
	endfunction

	function automatic chpi_pkg::in_beat_t rand_beat(chpi_pkg::mode_t m);
		chpi_pkg::in_beat_t b;
		b.mode      = m;
		b.pos_x     = rand_q16();
		b.pos_y     = rand_q16();
		b.pos_angle = rand_q16();
		b.vel_x     = rand_q16();
		b.vel_y     = rand_q16();
		b.vel_angle = rand_q16();
		b.step_time = rand_step();
		b.fraction  = rand_fraction();
		return b;
	endfunction

	function automatic chpi_pkg::in_beat_t pose_beat(chpi_pkg::mode_t m,
			logic [31:0] p, logic [31:0] v, logic [15:0] dt, logic [16:0] ds);
		chpi_pkg::in_beat_t b;
		b           = rand_beat(m);
		b.pos_x     = p;
		b.pos_y     = p;
		b.pos_angle = p;
		b.vel_x     = v;
		b.vel_y     = v;
		b.vel_angle = v;
		b.step_time = dt;
		b.fraction  = ds;
		return b;
	endfunction

	task automatic advance_pose_model(input chpi_pkg::in_beat_t b);
		longint              pos[3];
		longint              vel[3];
		longint              dt;
		longint              ds;
		longint              v0;
		longint              s;
		longint              dx;
		longint              a;
		longint              h;
		longint              e;
		chpi_pkg::out_beat_t r;
		pos[0] = clamp_value($signed(b.pos_x));
		pos[1] = clamp_value($signed(b.pos_y));
		pos[2] = clamp_value($signed(b.pos_angle));
		vel[0] = clamp_value($signed(b.vel_x));
		vel[1] = clamp_value($signed(b.vel_y));
		vel[2] = clamp_value($signed(b.vel_angle));
		dt = b.step_time;
		ds = b.fraction;
		case (b.mode)
			chpi_pkg::MODE_BEGIN: begin
				if (!body_static) begin
					for (int c = 0; c < 3; c++) begin
						pose_hold[c] = pos[c];
						rate_hold[c] = vel[c];
					end
				end
			end
			chpi_pkg::MODE_END: begin
				if (!body_static) begin
					for (int c = 0; c < 3; c++) begin
						v0 = rate_hold[c];
						s  = vel[c] + v0;
						dx = pos[c] - pose_hold[c];
						hermite_coef[3][c] = clamp_value(q16_round(dt * s) - 2 * dx);
						hermite_coef[2][c] = clamp_value(q16_round(-(dt * (s + v0))) + 3 * dx);
						hermite_coef[1][c] = clamp_value(q16_round(dt * v0));
						hermite_coef[0][c] = pose_hold[c];
					end
				end
			end
			chpi_pkg::MODE_UPDATE: begin
				if (!body_static) begin
					for (int c = 0; c < 3; c++) begin
						a = clamp_value(q16_round(ds * hermite_coef[3][c]) + hermite_coef[2][c]);
						h = clamp_value(q16_round(ds * a) + hermite_coef[1][c]);
						e = clamp_value(q16_round(ds * (3 * hermite_coef[3][c]))
							+ 2 * hermite_coef[2][c]);
						pose_hold[c] = clamp_value(q16_round(ds * h) + hermite_coef[0][c]);
						rate_hold[c] = clamp_value(q16_round(ds * e) + hermite_coef[1][c]);
					end
				end
				r.out_x      = 32'(pose_hold[0]);
				r.out_y      = 32'(pose_hold[1]);
				r.out_angle  = 32'(pose_hold[2]);
				r.out_dx     = 32'(rate_hold[0]);
				r.out_dy     = 32'(rate_hold[1]);
				r.out_dangle = 32'(rate_hold[2]);
				expected_poses.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_beat(input chpi_pkg::in_beat_t b);
		int gap;
		gap = (source_throttle && $urandom_range(0, 2) == 0) ? gap_length() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat  <= b;
		do @(posedge clk); while (in_stall);
		advance_pose_model(b);
		if (b.mode != chpi_pkg::MODE_NOP) beats_sent++;
		if (b.mode == chpi_pkg::MODE_UPDATE) updates_sent++;
	endtask

	// hold off until every pose is back, then let a trailing end beat finish
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_static(input bit v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		body_static = v;
		static_writes++;
		cfg_we <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d %s: expected %0d, actual %0d",
					results_checked, name, $signed(want), $signed(got));
		end
	endtask

	always @(posedge clk) begin
		chpi_pkg::out_beat_t want;
		if (out_valid && !out_stall) begin
			results_checked++;
			if (expected_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no pose pending", results_checked);
			end else begin
				want = expected_poses.pop_front();
				compare_field("out_x", want.out_x, out_beat.out_x);
				compare_field("out_y", want.out_y, out_beat.out_y);
				compare_field("out_angle", want.out_angle, out_beat.out_angle);
				compare_field("out_dx", want.out_dx, out_beat.out_dx);
				compare_field("out_dy", want.out_dy, out_beat.out_dy);
				compare_field("out_dangle", want.out_dangle, out_beat.out_dangle);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (sink_throttle && $urandom_range(0, 3) == 0) begin
			stall_left <= gap_length() - 1;
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("cubic_hermite_pose_interpolator: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_extreme_values();
		source_throttle = 1'b0;
		sink_throttle   = 1'b0;
		send_beat(pose_beat(chpi_pkg::MODE_BEGIN,
			32'h7fff_ffff, 32'h7fff_ffff, 16'h1234, 17'd5));
		send_beat(pose_beat(chpi_pkg::MODE_END,
			32'h8000_0000, 32'h8000_0000, 16'hffff, 17'd0));
		send_beat(pose_beat(chpi_pkg::MODE_UPDATE, 32'h0, 32'h0, 16'h0, 17'd0));
		send_beat(pose_beat(chpi_pkg::MODE_UPDATE, 32'h0, 32'h0, 16'h0, 17'd65536));
		send_beat(pose_beat(chpi_pkg::MODE_UPDATE, 32'h0, 32'h0, 16'h0, 17'd131071));
		send_beat(pose_beat(chpi_pkg::MODE_BEGIN,
			32'h8000_0000, 32'h8000_0000, 16'h0, 17'd0));
		send_beat(pose_beat(chpi_pkg::MODE_END,
			32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 17'd0));
		send_beat(pose_beat(chpi_pkg::MODE_UPDATE, 32'h0, 32'h0, 16'h0, 17'd131071));
		send_beat(pose_beat(chpi_pkg::MODE_UPDATE, 32'h0, 32'h0, 16'h0, 17'd32768));
		send_beat(pose_beat(chpi_pkg::MODE_BEGIN, 32'h0, 32'h0001_0000, 16'h0, 17'd0));
		send_beat(pose_beat(chpi_pkg::MODE_END,
			32'h0002_0000, 32'hffff_ffff, 16'h0, 17'd0));
		send_beat(pose_beat(chpi_pkg::MODE_UPDATE, 32'h0, 32'h0, 16'h0, 17'd1));
		send_beat(pose_beat(chpi_pkg::MODE_UPDATE, 32'h0, 32'h0, 16'h0, 17'd65536));
	endtask

	task automatic test_unused_mode();
		send_beat('1);
		send_beat(rand_beat(chpi_pkg::MODE_NOP));
		send_beat(pose_beat(chpi_pkg::MODE_UPDATE, 32'h0, 32'h0, 16'h0, 17'd32768));
	endtask

	task automatic test_static_body();
		source_throttle = 1'b1;
		sink_throttle   = 1'b1;
		write_static(1'b1);
		send_beat(rand_beat(chpi_pkg::MODE_BEGIN));
		send_beat(rand_beat(chpi_pkg::MODE_END));
		send_beat(rand_beat(chpi_pkg::MODE_UPDATE));
		send_beat(rand_beat(chpi_pkg::MODE_NOP));
		send_beat(rand_beat(chpi_pkg::MODE_UPDATE));
		write_static(1'b0);
		send_beat(rand_beat(chpi_pkg::MODE_UPDATE));
	endtask

	task automatic test_random_sequences();
		int target;
		int n;
		for (int chunk = 0; chunk < 4; chunk++) begin
			if (chunk == 2) write_static(1'b1);
			if (chunk == 3) write_static(1'b0);
			source_throttle = (chunk != 1);
			sink_throttle   = (chunk != 1);
			target = beats_sent + ((chunk == 2) ? STATIC_BEATS : CHUNK_BEATS);
			while (beats_sent < target) begin
				if ($urandom_range(0, 99) < 85) begin
					send_beat(rand_beat(chpi_pkg::MODE_BEGIN));
					send_beat(rand_beat(chpi_pkg::MODE_END));
					n = $urandom_range(1, 6);
					repeat (n) send_beat(rand_beat(chpi_pkg::MODE_UPDATE));
				end else begin
					send_beat(rand_beat(chpi_pkg::mode_t'(2'($urandom_range(0, 3)))));
				end
				if ($urandom_range(0, 59) == 0) drain_results();
			end
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		in_valid  = 1'b0;
		in_beat   = '0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_static(1'b0);
		test_extreme_values();
		test_unused_mode();
		test_static_body();
		test_random_sequences();
		drain_results();
		$display("%0d beats sent (%0d updates), %0d pose results checked, %0d register writes",
			beats_sent, updates_sent, results_checked, static_writes);
		$display("covered saturating extremes, extrapolated fractions, no-op and static-body beats");
		if (mismatches == 0 && expected_poses.size() == 0) begin
			$display("cubic_hermite_pose_interpolator: match");
		end else begin
			$display("cubic_hermite_pose_interpolator: mismatch");
		end
		$finish;
	end

endmodule
